### design/mfb_pkg.sv
// ----------------------------------------------------------------------------
// mfb_pkg
// command codes and controller/datapath handshake types for the blitter
// ----------------------------------------------------------------------------
`default_nettype none

package mfb_pkg;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_PIXEL = 3'd1;
  localparam logic [2:0] CMD_HLINE = 3'd2;
  localparam logic [2:0] CMD_VLINE = 3'd3;
  localparam logic [2:0] CMD_BLIT  = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  typedef struct packed {
    logic load;       // capture input beat
    logic setup;      // register the work plan
    logic rd;         // issue store read for current step
    logic upd;        // merge/write or gather for current step
    logic step_next;  // advance step counter
    logic clr_wr;     // write zero at step counter
    logic out_load;   // move gathered byte to output register
  } mfb_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_read;
    logic skip;
    logic step_last;
    logic clr_last;
    logic out_free;
  } mfb_stat_t;

endpackage

`default_nettype wire

### design/mfb_ctrl.sv
// ----------------------------------------------------------------------------
// mfb_ctrl
// sequencer for clear sweep, read-modify-write steps and readout
// ----------------------------------------------------------------------------
`default_nettype none

module mfb_ctrl
  import mfb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire mfb_stat_t stat,
  output mfb_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SETUP,
    S_DISPATCH,
    S_RD,
    S_UPD,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr    = 1'b1;
        cmd.step_next = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.is_clear)                state_nxt = S_CLR;
        else if (stat.is_read && stat.skip) state_nxt = S_OUT;
        else if (stat.skip)               state_nxt = S_IDLE;
        else                              state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (stat.step_last) begin
          state_nxt = stat.is_read ? S_OUT : S_IDLE;
        end else begin
          cmd.step_next = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_OUT: begin
        // wait until the previous result beat has left
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### design/mfb_dpath.sv
// ----------------------------------------------------------------------------
// mfb_dpath
// frame store, step address/mask generation, merge and readout gather
// ----------------------------------------------------------------------------
`default_nettype none

module mfb_dpath
  import mfb_pkg::*;
#(
  parameter int DISP_WIDTH  = 128,
  parameter int DISP_HEIGHT = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mfb_cmd_t           cmd,
  output mfb_stat_t               stat,
  input  wire logic        [2:0]  in_cmd,
  input  wire logic signed [10:0] in_coord_x,
  input  wire logic signed [10:0] in_coord_y,
  input  wire logic signed [10:0] in_coord_end,
  input  wire logic        [7:0]  in_sprite_hot_x,
  input  wire logic        [7:0]  in_sprite_hot_y,
  input  wire logic        [7:0]  in_row_index,
  input  wire logic        [31:0] in_mask_word,
  input  wire logic        [31:0] in_image_word,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic             [7:0]  out_raw_byte
);

  localparam int ROW_WORDS   = (DISP_WIDTH + 31) / 32;
  localparam int STORE_WORDS = ROW_WORDS * DISP_HEIGHT;
  localparam int PAGES       = (DISP_HEIGHT + 7) / 8;
  localparam int AW          = $clog2(STORE_WORDS);
  localparam int RBW         = $clog2(DISP_HEIGHT);
  localparam int WBW         = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;

  localparam logic [AW-1:0]      LAST_ADDR  = AW'(STORE_WORDS - 1);
  localparam logic signed [11:0] W_MAX      = 12'(DISP_WIDTH - 1);
  localparam logic signed [11:0] H_MAX      = 12'(DISP_HEIGHT - 1);
  localparam logic signed [11:0] PAGES_S    = 12'(PAGES);
  localparam logic signed [11:0] BLIT_MIN_X = -12'sd31;
  localparam logic [6:0]         WI_LAST    = 7'(ROW_WORDS - 1);

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] d;
    d = {v, v} << n;
    return d[63:32];
  endfunction

  // frame store
  logic [31:0] mem [STORE_WORDS];
  logic [31:0] rdata_r;

  // captured beat
  logic        [2:0]  cmd_r;
  logic signed [11:0] px_r, py_r, e_r;
  logic        [31:0] mask_r, img_r;

  // work plan
  logic          skip_r;
  logic [AW-1:0] first_r, last_r, cnt_r;
  logic [RBW-1:0] row_r, pb_r;
  logic [WBW-1:0] wi_r;
  logic [4:0]    col5_r, lo5_r, hi5_r;
  logic [31:0]   rm_r, ri_r, lmask_r;
  logic          neg_r;

  // current step
  logic [AW-1:0] addr_r;
  logic [31:0]   m_r, p_r;
  logic [7:0]    byte_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;

  // ---------------- capture ----------------
  logic signed [11:0] x_ext, y_ext, bx, by;

  always_comb begin
    x_ext = 12'(in_coord_x);
    y_ext = 12'(in_coord_y);
    bx    = x_ext - $signed({4'b0000, in_sprite_hot_x});
    by    = y_ext - $signed({4'b0000, in_sprite_hot_y}) + $signed({4'b0000, in_row_index});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      px_r   <= (in_cmd == CMD_BLIT) ? bx : x_ext;
      py_r   <= (in_cmd == CMD_BLIT) ? by : y_ext;
      e_r    <= 12'(in_coord_end);
      mask_r <= in_mask_word;
      img_r  <= in_image_word;
    end
  end

  // ---------------- plan ----------------
  logic               x_in, y_in, rd_ok;
  logic signed [11:0] h_lo, h_hi, v_lo, v_hi, hlo_c, hhi_c, vlo_c, vhi_c, rem;
  logic        [7:0]  pb8;
  logic        [2:0]  rd_last;
  logic        [4:0]  rot;
  logic               skip_nxt;
  logic [AW-1:0]      first_nxt, last_nxt;

  always_comb begin
    x_in  = (px_r >= 0) && (px_r <= W_MAX);
    y_in  = (py_r >= 0) && (py_r <= H_MAX);
    h_lo  = (px_r < e_r) ? px_r : e_r;
    h_hi  = (px_r < e_r) ? e_r : px_r;
    v_lo  = (py_r < e_r) ? py_r : e_r;
    v_hi  = (py_r < e_r) ? e_r : py_r;
    hlo_c = (h_lo < 0) ? 12'sd0 : h_lo;
    hhi_c = (h_hi > W_MAX) ? W_MAX : h_hi;
    vlo_c = (v_lo < 0) ? 12'sd0 : v_lo;
    vhi_c = (v_hi > H_MAX) ? H_MAX : v_hi;
    rd_ok = x_in && (py_r >= 0) && (py_r < PAGES_S);
    pb8   = {py_r[4:0], 3'b000};
    rem   = H_MAX - $signed({4'b0000, pb8});
    rd_last = (rem > 12'sd7) ? 3'd7 : rem[2:0];
    rot   = px_r[4:0];

    skip_nxt  = 1'b1;
    first_nxt = '0;
    last_nxt  = '0;
    case (cmd_r)
      CMD_CLEAR: begin
        skip_nxt = 1'b0;
        last_nxt = LAST_ADDR;
      end
      CMD_PIXEL: skip_nxt = !(x_in && y_in);
      CMD_HLINE: begin
        skip_nxt  = !y_in || (h_lo > W_MAX) || (h_hi < 0);
        first_nxt = AW'(hlo_c[11:5]);
        last_nxt  = AW'(hhi_c[11:5]);
      end
      CMD_VLINE: begin
        skip_nxt  = !x_in || (v_lo == v_hi) || (v_lo > H_MAX) || (v_hi < 0);
        first_nxt = AW'(vlo_c);
        last_nxt  = AW'(vhi_c);
      end
      CMD_BLIT: begin
        skip_nxt  = (px_r < BLIT_MIN_X) || (px_r > W_MAX) || !y_in;
        // negative x writes only the low part into the row's first word
        first_nxt = AW'(px_r[11]);
        last_nxt  = AW'(px_r[11] || ((rot != 5'd0) && (px_r[11:5] < WI_LAST)));
      end
      CMD_READ: begin
        skip_nxt = !rd_ok;
        last_nxt = AW'(rd_last);
      end
      default: skip_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      skip_r  <= skip_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      row_r   <= py_r[RBW-1:0];
      pb_r    <= RBW'(pb8);
      wi_r    <= px_r[5 +: WBW];
      col5_r  <= px_r[4:0];
      lo5_r   <= hlo_c[4:0];
      hi5_r   <= hhi_c[4:0];
      rm_r    <= rotl32(mask_r, rot);
      ri_r    <= rotl32(img_r, rot);
      lmask_r <= 32'hffff_ffff << rot;
      neg_r   <= px_r[11];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.setup) begin
      cnt_r <= first_nxt;
    end else if (cmd.step_next) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // ---------------- step address and mask ----------------
  logic [RBW-1:0] row_c;
  logic [WBW-1:0] word_c;
  logic [31:0]    m_c, p_c, bit_c, lom, him;
  logic [AW-1:0]  addr_c;

  always_comb begin
    bit_c  = 32'd1 << col5_r;
    lom    = (cnt_r == first_r) ? (32'hffff_ffff << lo5_r) : 32'hffff_ffff;
    him    = (cnt_r == last_r) ? (32'hffff_ffff >> (5'd31 - hi5_r)) : 32'hffff_ffff;
    row_c  = row_r;
    word_c = wi_r;
    m_c    = '0;
    p_c    = 32'hffff_ffff;
    case (cmd_r)
      CMD_PIXEL: m_c = bit_c;
      CMD_HLINE: begin
        word_c = cnt_r[WBW-1:0];
        m_c    = lom & him;
      end
      CMD_VLINE: begin
        row_c = cnt_r[RBW-1:0];
        m_c   = bit_c;
      end
      CMD_BLIT: begin
        p_c = ri_r;
        if (!cnt_r[0]) begin
          m_c = rm_r & lmask_r;
        end else begin
          word_c = neg_r ? '0 : wi_r + 1'b1;
          m_c    = rm_r & ~lmask_r;
        end
      end
      CMD_READ: row_c = pb_r + RBW'(cnt_r[2:0]);
      default: m_c = '0;
    endcase
    addr_c = AW'(int'(row_c) * ROW_WORDS + int'(word_c));
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      addr_r <= addr_c;
      m_r    <= m_c;
      p_r    <= p_c;
    end
  end

  // ---------------- store ----------------
  logic          is_read, we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  always_comb begin
    is_read = (cmd_r == CMD_READ);
    we      = cmd.clr_wr || (cmd.upd && !is_read);
    waddr   = cmd.clr_wr ? cnt_r : addr_r;
    wdata   = cmd.clr_wr ? 32'd0 : ((rdata_r & ~m_r) | (p_r & m_r));
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) rdata_r <= mem[addr_c];
  end

  // ---------------- readout ----------------
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      byte_r <= '0;
    end else if (cmd.upd && is_read) begin
      byte_r[cnt_r[2:0]] <= rdata_r[col5_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_byte_r <= byte_r;
  end

  assign out_valid    = out_valid_r;
  assign out_raw_byte = out_byte_r;

  always_comb begin
    stat.is_clear  = (cmd_r == CMD_CLEAR);
    stat.is_read   = is_read;
    stat.skip      = skip_r;
    stat.step_last = (cnt_r == last_r);
    stat.clr_last  = (cnt_r == LAST_ADDR);
    stat.out_free  = !out_valid_r || !out_stall;
  end

endmodule

`default_nettype wire

### design/mono_framebuffer_draw_blit_unit.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_blit_unit
// one-bit frame store with clear, pixel, line, sprite-row blit and readout
// ----------------------------------------------------------------------------
// input channel in_*: one command beat, taken when in_valid is high and
//   in_stall is low; in_stall stays high while a command is being worked on
// output channel out_*: one raw_byte beat per readout command only
// the store is ceil(DISP_WIDTH/32)*DISP_HEIGHT row words in one memory with
//   one write and one registered read port; every drawing word is a
//   read-modify-write, a read step then a merge-and-write step
// steps per command after it is accepted (none when nothing is drawn):
//   pixel one word, horizontal line one step per touched word, vertical line
//   one step per row, blit row one or two words, clear every store word,
//   readout one step per row read (up to 8), result beat appears after that
// reset: a zeroing sweep of one word per cycle over the whole store
//   (256 words at the default size) runs before the first beat is taken
// a stalled result beat holds in its output register; the next command is
//   still taken, and a following readout waits only at its very end
// ----------------------------------------------------------------------------
`default_nettype none

module mono_framebuffer_draw_blit_unit
  import mfb_pkg::*;
#(
  parameter int DISP_WIDTH  = 128,
  parameter int DISP_HEIGHT = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [2:0]  in_cmd,
  input  wire logic signed [10:0] in_coord_x,
  input  wire logic signed [10:0] in_coord_y,
  input  wire logic signed [10:0] in_coord_end,
  input  wire logic        [7:0]  in_sprite_hot_x,
  input  wire logic        [7:0]  in_sprite_hot_y,
  input  wire logic        [7:0]  in_row_index,
  input  wire logic        [31:0] in_mask_word,
  input  wire logic        [31:0] in_image_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [7:0]  out_raw_byte
);

  mfb_cmd_t  cmd;
  mfb_stat_t stat;

  mfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mfb_dpath #(
    .DISP_WIDTH  (DISP_WIDTH),
    .DISP_HEIGHT (DISP_HEIGHT)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_cmd          (in_cmd),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_end    (in_coord_end),
    .in_sprite_hot_x (in_sprite_hot_x),
    .in_sprite_hot_y (in_sprite_hot_y),
    .in_row_index    (in_row_index),
    .in_mask_word    (in_mask_word),
    .in_image_word   (in_image_word),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_raw_byte    (out_raw_byte)
  );

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the one-bit frame store: drives draw, blit, clear
//   and readout commands with random gaps and result stalls, mirrors the store
//   in a scoreboard and compares every readout byte in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import mfb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DISP_WIDTH     = 128;
  localparam int DISP_HEIGHT    = 64;
  localparam int ROW_WORDS      = (DISP_WIDTH + 31) / 32;
  localparam int STORE_WORDS    = ROW_WORDS * DISP_HEIGHT;
  localparam int RANDOM_ITEMS   = 700;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 400;

  // codes the block ignores
  localparam logic [2:0] CMD_NOP6 = 3'd6;
  localparam logic [2:0] CMD_NOP7 = 3'd7;

  typedef struct {
    logic        [2:0]  cmd;
    logic signed [10:0] x;
    logic signed [10:0] y;
    logic signed [10:0] e;
    logic        [7:0]  hx;
    logic        [7:0]  hy;
    logic        [7:0]  ri;
    logic        [31:0] mask;
    logic        [31:0] img;
  } fb_beat_t;

  class fb_mirror;
    logic [31:0] words [STORE_WORDS];
    logic [7:0]  pending_bytes [$];
    int          errors;

    function new();
      foreach (words[i]) words[i] = '0;
      errors = 0;
    endfunction

    function void set_px(int x, int y);
      if (x >= 0 && x < DISP_WIDTH && y >= 0 && y < DISP_HEIGHT)
        words[y * ROW_WORDS + (x >> 5)][x & 31] = 1'b1;
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int n);
      n = n & 31;
      if (n == 0) return v;
      return (v << n) | (v >> (32 - n));
    endfunction

    function void put_masked(int idx, logic [31:0] m, logic [31:0] p);
      if (idx < STORE_WORDS) words[idx] = (words[idx] & ~m) | (p & m);
    endfunction

    function void note_command(fb_beat_t b);
      int x, y, e, lo, hi, bx, by, base, rot, wi, r;
      logic [31:0] lmask, rm, rimg;
      logic [7:0]  rd;
      x = b.x;
      y = b.y;
      e = b.e;
      case (b.cmd)
        CMD_CLEAR: foreach (words[i]) words[i] = '0;
        CMD_PIXEL: set_px(x, y);
        CMD_HLINE: begin
          if (y >= 0 && y < DISP_HEIGHT) begin
            lo = (x < e) ? x : e;
            hi = (x < e) ? e : x;
            if (lo < 0) lo = 0;
            if (hi > DISP_WIDTH - 1) hi = DISP_WIDTH - 1;
            for (int i = lo; i <= hi; i++) set_px(i, y);
          end
        end
        CMD_VLINE: begin
          lo = (y < e) ? y : e;
          hi = (y < e) ? e : y;
          if (!(x < 0 || x > DISP_WIDTH - 1 || lo == hi || lo > DISP_HEIGHT - 1 || hi < 0))
          begin
            if (lo < 0) lo = 0;
            if (hi > DISP_HEIGHT - 1) hi = DISP_HEIGHT - 1;
            for (int i = lo; i <= hi; i++) set_px(x, i);
          end
        end
        CMD_BLIT: begin
          bx = x - int'(b.hx);
          by = y - int'(b.hy) + int'(b.ri);
          if (bx >= -31 && bx <= DISP_WIDTH - 1 && by >= 0 && by <= DISP_HEIGHT - 1) begin
            base = by * ROW_WORDS;
            if (bx < 0) begin
              // sprite hangs off the left edge: only the wrapped part lands
              rot   = bx + 32;
              lmask = 32'hffffffff << rot;
              rm    = rotl(b.mask, rot);
              rimg  = rotl(b.img, rot);
              put_masked(base, rm & ~lmask, rimg & ~lmask);
            end else begin
              rot   = bx & 31;
              wi    = bx >> 5;
              lmask = 32'hffffffff << rot;
              rm    = rotl(b.mask, rot);
              rimg  = rotl(b.img, rot);
              put_masked(base + wi, rm & lmask, rimg & lmask);
              if (rot != 0 && wi < ROW_WORDS - 1)
                put_masked(base + wi + 1, rm & ~lmask, rimg & ~lmask);
            end
          end
        end
        CMD_READ: begin
          rd = '0;
          if (!(x < 0 || x >= DISP_WIDTH || y < 0)) begin
            for (int k = 0; k < 8; k++) begin
              r = y * 8 + k;
              if (r < DISP_HEIGHT && words[r * ROW_WORDS + (x >> 5)][x & 31]) rd[k] = 1'b1;
            end
          end
          pending_bytes.push_back(rd);
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [7:0] got);
      logic [7:0] want;
      if (pending_bytes.size() == 0) begin
        $display("[%0t] raw_byte beat with nothing expected: actual %02h", $time, got);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (got !== want) begin
          $display("[%0t] raw_byte mismatch: expected %02h, actual %02h", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic        [2:0]  in_cmd = CMD_CLEAR;
  logic signed [10:0] in_coord_x = '0;
  logic signed [10:0] in_coord_y = '0;
  logic signed [10:0] in_coord_end = '0;
  logic        [7:0]  in_sprite_hot_x = '0;
  logic        [7:0]  in_sprite_hot_y = '0;
  logic        [7:0]  in_row_index = '0;
  logic        [31:0] in_mask_word = '0;
  logic        [31:0] in_image_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic        [7:0]  out_raw_byte;

  fb_mirror mirror = new();
  int       quiet_cycles = 0;

  mono_framebuffer_draw_blit_unit #(
    .DISP_WIDTH (DISP_WIDTH),
    .DISP_HEIGHT(DISP_HEIGHT)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_end   (in_coord_end),
    .in_sprite_hot_x(in_sprite_hot_x),
    .in_sprite_hot_y(in_sprite_hot_y),
    .in_row_index   (in_row_index),
    .in_mask_word   (in_mask_word),
    .in_image_word  (in_image_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_raw_byte   (out_raw_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic fb_beat_t mk_beat(logic [2:0] cmd, int x, int y, int e, int hx, int hy,
                                       int ri, logic [31:0] mask, logic [31:0] img);
    fb_beat_t b;
    b.cmd  = cmd;
    b.x    = 11'(x);
    b.y    = 11'(y);
    b.e    = 11'(e);
    b.hx   = 8'(hx);
    b.hy   = 8'(hy);
    b.ri   = 8'(ri);
    b.mask = mask;
    b.img  = img;
    return b;
  endfunction

  // mostly short, some medium, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // coordinate in a window around the picture, now and then any 11-bit value
  function automatic int pick(int lo, int hi);
    if ($urandom_range(0, 9) == 0) return int'($urandom);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int pick8(int hi);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, hi);
  endfunction

  // hold one command beat until it is taken
  task automatic send_beat(fb_beat_t b);
    in_valid        <= 1'b1;
    in_cmd          <= b.cmd;
    in_coord_x      <= b.x;
    in_coord_y      <= b.y;
    in_coord_end    <= b.e;
    in_sprite_hot_x <= b.hx;
    in_sprite_hot_y <= b.hy;
    in_row_index    <= b.ri;
    in_mask_word    <= b.mask;
    in_image_word   <= b.img;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop sending until every readout byte is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mirror.pending_bytes.size() != 0) @(posedge clk);
  endtask

  // result side stall pattern
  initial begin
    int f, s;
    forever begin
      if ($urandom_range(0, 19) == 0) f = $urandom_range(100, 300);
      else f = $urandom_range(1, 12);
      out_stall <= 1'b0;
      repeat (f) @(posedge clk);
      s = gap_len();
      if (s > 0) begin
        out_stall <= 1'b1;
        repeat (s) @(posedge clk);
      end
    end
  end

  // beat monitor, scoreboard hookup and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_valid && !in_stall)
        mirror.note_command('{in_cmd, in_coord_x, in_coord_y, in_coord_end, in_sprite_hot_x,
                              in_sprite_hot_y, in_row_index, in_mask_word, in_image_word});
      if (out_valid && !out_stall) mirror.check_byte(out_raw_byte);
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no beat for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    fb_beat_t directed [$];
    fb_beat_t b;
    int       sent, r;
    bit       gaps_on;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners, off-picture pixels and extreme coordinates
    directed.push_back(mk_beat(CMD_PIXEL, 0, 0, 0, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_PIXEL, 127, 63, 0, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_PIXEL, -1, 64, 0, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_PIXEL, 1023, -1024, -1024, 255, 255, 255,
                               32'hffffffff, 32'hffffffff));
    directed.push_back(mk_beat(CMD_READ, 0, 0, 0, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_READ, 127, 7, 0, 0, 0, 0, '0, '0));
    // reversed ends clipped on both sides, line above the picture
    directed.push_back(mk_beat(CMD_HLINE, 200, 10, -5, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_HLINE, 0, -1, 50, 0, 0, 0, '0, '0));
    // equal ends, reversed and clipped, column off the right, span below
    directed.push_back(mk_beat(CMD_VLINE, 5, 20, 20, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_VLINE, 127, 70, -10, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_VLINE, 128, 0, 10, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_VLINE, 9, 64, 100, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_READ, 5, 2, 0, 0, 0, 0, '0, '0));
    // left-edge wrap, one past it, last column, word aligned, mid word
    directed.push_back(mk_beat(CMD_BLIT, 0, 0, 0, 31, 0, 1, 32'hffffffff, 32'ha5a5a5a5));
    directed.push_back(mk_beat(CMD_BLIT, 0, 0, 0, 32, 0, 2, 32'hffffffff, 32'hffffffff));
    directed.push_back(mk_beat(CMD_BLIT, 127, 5, 0, 0, 5, 63, 32'hff00ff00, 32'hffffffff));
    directed.push_back(mk_beat(CMD_BLIT, 32, 10, 0, 0, 255, 255, 32'hffffffff, 32'h00000000));
    directed.push_back(mk_beat(CMD_BLIT, 45, 40, 0, 0, 0, 0, 32'h0f0f0f0f, 32'h3c3c3c3c));
    directed.push_back(mk_beat(CMD_READ, 0, 0, 0, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_READ, -1, 0, 0, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_READ, 128, 0, 0, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_READ, 0, 8, 0, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_READ, 0, -1, 0, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_READ, 1023, 1023, 0, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_NOP6, 3, 3, 3, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_NOP7, 3, 3, 3, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0, '0, '0));
    directed.push_back(mk_beat(CMD_READ, 127, 7, 0, 0, 0, 0, '0, '0));

    foreach (directed[i]) begin
      send_beat(directed[i]);
      pause(gap_len());
    end
    drain();

    sent    = 0;
    gaps_on = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      b = mk_beat(CMD_CLEAR, pick(-40, 170), pick(-10, 75), pick(-40, 170), pick8(40),
                  pick8(40), pick8(31), $urandom, $urandom);
      if ($urandom_range(0, 9) == 0) b.mask = ($urandom_range(0, 1) != 0) ? '1 : '0;
      r = $urandom_range(0, 99);
      if (r < 2) b.cmd = CMD_CLEAR;
      else if (r < 20) b.cmd = CMD_PIXEL;
      else if (r < 32) b.cmd = CMD_HLINE;
      else if (r < 44) begin
        b.cmd = CMD_VLINE;
        b.x   = 11'(pick(-4, 131));
        b.e   = ($urandom_range(0, 6) == 0) ? b.y : 11'(pick(-10, 75));
      end else if (r < 66) b.cmd = CMD_BLIT;
      else if (r < 96) begin
        b.cmd = CMD_READ;
        b.x   = 11'(pick(-4, 131));
        b.y   = 11'(pick(-1, 8));
      end else b.cmd = ($urandom_range(0, 1) != 0) ? CMD_NOP6 : CMD_NOP7;
      send_beat(b);
      if (b.cmd != CMD_NOP6 && b.cmd != CMD_NOP7) sent++;
      if (sent == RANDOM_ITEMS / 2) drain();
      else pause(gaps_on ? gap_len() : 0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.pending_bytes.size() != 0) begin
      $display("[%0t] %0d readout bytes never arrived", $time, mirror.pending_bytes.size());
      mirror.errors++;
    end
    if (mirror.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
